FILE: sv/twg_pkg.sv
package twg_pkg;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_FETCH = 4'd0;
  localparam pc_t PC_EMIT  = 4'd1;
  localparam pc_t PC_STEP  = 4'd2;
  localparam pc_t PC_SIN0  = 4'd3;
  localparam pc_t PC_SIN1  = 4'd4;
  localparam pc_t PC_SIN2  = 4'd5;
  localparam pc_t PC_SIN3  = 4'd6;
  localparam pc_t PC_RMP0  = 4'd7;
  localparam pc_t PC_RMP1  = 4'd8;
  localparam pc_t PC_PAR0  = 4'd9;
  localparam pc_t PC_PAR1  = 4'd10;
  localparam pc_t PC_PAR2  = 4'd11;
  localparam pc_t PC_PAR3  = 4'd12;
  localparam pc_t PC_LAST  = PC_PAR3;

  localparam logic [1:0] WAVE_STEP     = 2'd0;
  localparam logic [1:0] WAVE_SINE     = 2'd1;
  localparam logic [1:0] WAVE_RAMP     = 2'd2;
  localparam logic [1:0] WAVE_PARABOLA = 2'd3;

  localparam logic [2:0] REG_WAVEFORM  = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE = 3'd1;
  localparam logic [2:0] REG_FREQUENCY = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_PHASE     = 3'd4;

  localparam logic [1:0] MA_AMP  = 2'd0;
  localparam logic [1:0] MA_TIME = 2'd1;
  localparam logic [1:0] MA_FREQ = 2'd2;

  localparam logic [1:0] MB_TIME = 2'd0;
  localparam logic [1:0] MB_SINE = 2'd1;
  localparam logic [1:0] MB_HI   = 2'd2;
  localparam logic [1:0] MB_LO   = 2'd3;

  localparam logic [2:0] ACC_NOP   = 3'd0;
  localparam logic [2:0] ACC_STEP  = 3'd1;
  localparam logic [2:0] ACC_OFS_P = 3'd2;
  localparam logic [2:0] ACC_ADD32 = 3'd3;
  localparam logic [2:0] ACC_SH15  = 3'd4;
  localparam logic [2:0] ACC_SH16  = 3'd5;

  localparam logic [1:0] NXT_SEQ      = 2'd0;
  localparam logic [1:0] NXT_GO       = 2'd1;
  localparam logic [1:0] NXT_DISPATCH = 2'd2;
  localparam logic [1:0] NXT_OUT_FREE = 2'd3;

  localparam int unsigned SINE_W = 15;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic [2:0] acc_op;
    logic       lo_en;
    logic       ang_en;
    logic       emit;
    logic [1:0] nxt;
    pc_t        target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t w;
    w = '0;
    w.nxt = NXT_SEQ;
    case (pc)
      PC_FETCH: begin
        w.nxt = NXT_DISPATCH;
      end
      PC_EMIT: begin
        w.emit   = 1'b1;
        w.nxt    = NXT_OUT_FREE;
        w.target = PC_FETCH;
      end
      PC_STEP: begin
        w.acc_op = ACC_STEP;
        w.nxt    = NXT_GO;
        w.target = PC_EMIT;
      end
      PC_SIN0: begin
        w.mul_en = 1'b1;
        w.a_sel  = MA_FREQ;
        w.b_sel  = MB_TIME;
      end
      PC_SIN1: begin
        w.ang_en = 1'b1;
      end
      PC_SIN2: begin
        w.mul_en = 1'b1;
        w.a_sel  = MA_AMP;
        w.b_sel  = MB_SINE;
      end
      PC_SIN3: begin
        w.acc_op = ACC_SH15;
        w.nxt    = NXT_GO;
        w.target = PC_EMIT;
      end
      PC_RMP0: begin
        w.mul_en = 1'b1;
        w.a_sel  = MA_AMP;
        w.b_sel  = MB_TIME;
      end
      PC_RMP1: begin
        w.acc_op = ACC_SH16;
        w.nxt    = NXT_GO;
        w.target = PC_EMIT;
      end
      PC_PAR0: begin
        w.mul_en = 1'b1;
        w.a_sel  = MA_TIME;
        w.b_sel  = MB_TIME;
      end
      PC_PAR1: begin
        w.mul_en = 1'b1;
        w.a_sel  = MA_AMP;
        w.b_sel  = MB_HI;
        w.lo_en  = 1'b1;
      end
      PC_PAR2: begin
        w.mul_en = 1'b1;
        w.a_sel  = MA_AMP;
        w.b_sel  = MB_LO;
        w.acc_op = ACC_OFS_P;
      end
      PC_PAR3: begin
        w.acc_op = ACC_ADD32;
        w.nxt    = NXT_GO;
        w.target = PC_EMIT;
      end
      default: begin
        w.nxt    = NXT_GO;
        w.target = PC_FETCH;
      end
    endcase
    return w;
  endfunction

  function automatic pc_t wave_entry(input logic [1:0] wave);
    pc_t pc;
    case (wave)
      WAVE_STEP:     pc = PC_STEP;
      WAVE_SINE:     pc = PC_SIN0;
      WAVE_RAMP:     pc = PC_RMP0;
      WAVE_PARABOLA: pc = PC_PAR0;
      default:       pc = PC_STEP;
    endcase
    return pc;
  endfunction

  // Quarter-wave sine entry k of 2^bits, Q0.15, from a Taylor series in Q30
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    int unsigned        j;
    x    = (HALF_PI_Q30 * 64'(k)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (j = 1; j <= 7; j++) begin
      term = (term * x2) >> 30;
      case (j)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (j[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    return sum[SINE_W-1:0];
  endfunction

endpackage

FILE: sv/test_waveform_generator.sv
// Test waveform generator: each transfer on the input channel carries a signed
// time step, which is added to a saturating Q16.16 elapsed-time register; the
// block then returns one 32-bit saturated sample of the selected waveform
// (step, sine, ramp or parabola) scaled by amplitude and shifted by offset.
// A small microcode program steps a datapath built around one shared 33x33
// multiplier and a registered quarter-wave sine ROM of 2^SINE_TABLE_BITS + 1
// entries. After an input transfer the program runs STEP for step, RMP0 and
// RMP1 for ramp, SIN0 to SIN3 for sine or PAR0 to PAR3 for parabola; then
// EMIT loads the result when the output register is free, and the program is
// back at its fetch step in the same cycle that the result appears; input
// stalls until then. The next item is taken even while the previous result is
// still held in the output register; its program then waits at the emit step
// until the output register frees up. Any write to a listed register clears
// elapsed time; write configuration only while idle.
module test_waveform_generator
  import twg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int unsigned SINE_N = 1 << SINE_TABLE_BITS;
  localparam int unsigned ADDR_W = SINE_TABLE_BITS + 1;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_N];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned k = 0; k <= SINE_N; k++) begin
      rom[k] = sine_entry(k, SINE_TABLE_BITS);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [1:0]         waveform_r;
  logic signed [31:0] amplitude_r;
  logic [15:0]        frequency_r;
  logic signed [31:0] offset_r;
  logic [15:0]        phase_r;
  logic signed [31:0] time_r;
  pc_t                pc_r;
  pc_t                pc_nxt;
  logic               out_valid_r;
  logic signed [31:0] out_sample_r;
  logic signed [31:0] out_sample_nxt;
  logic signed [65:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [65:0] acc_nxt;
  logic [31:0]        lo_r;
  logic [SINE_W-1:0]  rom_q_r;
  logic               sine_neg_r;

  ctrl_word_t         cw;
  logic               in_xfer;
  logic               out_free;
  logic               cfg_wr;
  logic               cfg_hit;
  logic signed [32:0] time_sum;
  logic signed [31:0] time_nxt;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [16:0] sine_val;
  logic [15:0]        angle;
  logic [SINE_TABLE_BITS-1:0] sine_idx;
  logic [ADDR_W-1:0]  rom_addr;
  logic signed [65:0] offset_x;
  logic               sat_hi;
  logic               sat_lo;

  assign cw        = ucode(pc_r);
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index <= REG_PHASE);
  assign in_stall  = (pc_r != PC_FETCH);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign time_sum = 33'(time_r) + 33'(in_time_step);

  always_comb begin
    if (time_sum[32] != time_sum[31]) begin
      time_nxt = time_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      time_nxt = time_sum[31:0];
    end
  end

  always_comb begin
    pc_nxt = pc_r;
    case (cw.nxt)
      NXT_SEQ:      pc_nxt = pc_r + 1'b1;
      NXT_GO:       pc_nxt = cw.target;
      NXT_DISPATCH: pc_nxt = in_xfer ? wave_entry(waveform_r) : pc_r;
      NXT_OUT_FREE: pc_nxt = out_free ? cw.target : pc_r;
      default:      pc_nxt = PC_FETCH;
    endcase
  end

  // angle in turns, folded onto the quarter-wave ROM
  assign angle    = prod_r[23:8] + phase_r;
  assign sine_idx = angle[13 -: SINE_TABLE_BITS];
  assign rom_addr = angle[14] ? ADDR_W'(SINE_N) - {1'b0, sine_idx} : {1'b0, sine_idx};
  assign sine_val = sine_neg_r ? -$signed({2'b00, rom_q_r}) : $signed({2'b00, rom_q_r});

  always_comb begin
    case (cw.a_sel)
      MA_AMP:  mul_a = {amplitude_r[31], amplitude_r};
      MA_TIME: mul_a = {time_r[31], time_r};
      MA_FREQ: mul_a = {17'd0, frequency_r};
      default: mul_a = {amplitude_r[31], amplitude_r};
    endcase
    case (cw.b_sel)
      MB_TIME: mul_b = {time_r[31], time_r};
      MB_SINE: mul_b = {{16{sine_val[16]}}, sine_val};
      MB_HI:   mul_b = {1'b0, prod_r[63:32]};
      MB_LO:   mul_b = {1'b0, lo_r};
      default: mul_b = {time_r[31], time_r};
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign offset_x = 66'(offset_r);

  always_comb begin
    case (cw.acc_op)
      ACC_STEP:  acc_nxt = offset_x + (time_r[31] ? 66'sd0 : 66'(amplitude_r));
      ACC_OFS_P: acc_nxt = offset_x + prod_r;
      ACC_ADD32: acc_nxt = acc_r + (prod_r >>> 32);
      ACC_SH15:  acc_nxt = offset_x + (prod_r >>> 15);
      ACC_SH16:  acc_nxt = offset_x + (prod_r >>> 16);
      default:   acc_nxt = acc_r;
    endcase
  end

  assign sat_hi = !acc_r[65] && (|acc_r[64:31]);
  assign sat_lo = acc_r[65] && !(&acc_r[64:31]);

  always_comb begin
    if (sat_hi) begin
      out_sample_nxt = 32'sh7fff_ffff;
    end else if (sat_lo) begin
      out_sample_nxt = 32'sh8000_0000;
    end else begin
      out_sample_nxt = acc_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r  <= WAVE_STEP;
      amplitude_r <= '0;
      frequency_r <= '0;
      offset_r    <= '0;
      phase_r     <= '0;
      time_r      <= '0;
      pc_r        <= PC_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_WAVEFORM:  waveform_r  <= cfg_wdata[1:0];
          REG_AMPLITUDE: amplitude_r <= cfg_wdata;
          REG_FREQUENCY: frequency_r <= cfg_wdata[15:0];
          REG_OFFSET:    offset_r    <= cfg_wdata;
          REG_PHASE:     phase_r     <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        time_r <= '0;
      end else if (in_xfer) begin
        time_r <= time_nxt;
      end
      pc_r <= pc_nxt;
      if (cw.emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.mul_en) begin
      prod_r <= mul_p;
    end
    acc_r <= acc_nxt;
    if (cw.lo_en) begin
      lo_r <= prod_r[31:0];
    end
    if (cw.ang_en) begin
      rom_q_r    <= SINE_ROM[rom_addr];
      sine_neg_r <= angle[15];
    end
    if (cw.emit && out_free) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n) pc_r <= PC_LAST)
    else $error("microcode step counter left the program");

  a_fetch_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> pc_r != PC_FETCH)
    else $error("input transfer did not start a program");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == PC_EMIT)
    else $error("result loaded outside the emit step");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench
  import twg_pkg::*;
();

  localparam int unsigned SINE_BITS = 10;
  localparam int unsigned SINE_N = 1 << SINE_BITS;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic signed [32:0] TIME_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] TIME_MIN = 33'sh1_8000_0000;
  localparam logic signed [127:0] SAMPLE_MAX = 128'sd2147483647;
  localparam logic signed [127:0] SAMPLE_MIN = -128'sd2147483648;
  localparam logic [2:0] REG_INDEX_MAX = '1;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 150;

  class sample_scoreboard;
    logic [1:0]         wave_sel;
    logic signed [31:0] amplitude;
    logic [15:0]        freq;
    logic signed [31:0] offset_val;
    logic [15:0]        phase_val;
    logic signed [31:0] elapsed;
    logic [14:0]        quarter_sine [SINE_N+1];
    logic signed [31:0] expected_samples [$];
    int                 mismatches;

    function new();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      int unsigned k;
      int unsigned j;
      for (k = 0; k <= SINE_N; k++) begin
        x = (QUARTER_TURN_Q30 * 64'(k)) / 64'(SINE_N);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (j = 1; j <= 7; j++) begin
          term = (term * x2) >> 30;
          term = term / 64'((2 * j) * (2 * j + 1));
          if (j % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        sum = (sum + 16384) >>> 15;
        if (sum > 32767) begin
          sum = 32767;
        end
        quarter_sine[k] = sum[14:0];
      end
      wave_sel = WAVE_STEP;
      amplitude = '0;
      freq = '0;
      offset_val = '0;
      phase_val = '0;
      elapsed = '0;
      mismatches = 0;
    endfunction

    function void apply_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_WAVEFORM:  wave_sel = data[1:0];
        REG_AMPLITUDE: amplitude = data;
        REG_FREQUENCY: freq = data[15:0];
        REG_OFFSET:    offset_val = data;
        REG_PHASE:     phase_val = data[15:0];
        default:       return;
      endcase
      elapsed = '0;
    endfunction

    function logic signed [31:0] predict_sample(logic signed [15:0] ts);
      logic signed [32:0]  t_sum;
      logic signed [127:0] t_w;
      logic signed [127:0] amp_w;
      logic signed [127:0] sine_w;
      logic signed [127:0] r;
      logic [63:0]         turn_prod;
      logic [15:0]         angle;
      int unsigned         idx;
      t_sum = elapsed + ts;
      if (t_sum > TIME_MAX) begin
        t_sum = TIME_MAX;
      end else if (t_sum < TIME_MIN) begin
        t_sum = TIME_MIN;
      end
      elapsed = t_sum[31:0];
      t_w = elapsed;
      amp_w = amplitude;
      case (wave_sel)
        WAVE_STEP: begin
          r = offset_val;
          if (elapsed >= 0) begin
            r = amp_w + offset_val;
          end
        end
        WAVE_SINE: begin
          turn_prod = longint'(freq) * longint'(elapsed);
          angle = turn_prod[23:8] + phase_val;
          idx = angle[13:0] >> (14 - SINE_BITS);
          if (angle[14]) begin
            sine_w = quarter_sine[SINE_N - idx];
          end else begin
            sine_w = quarter_sine[idx];
          end
          if (angle[15]) begin
            sine_w = -sine_w;
          end
          r = ((amp_w * sine_w) >>> 15) + offset_val;
        end
        WAVE_RAMP: r = ((amp_w * t_w) >>> 16) + offset_val;
        default:   r = ((amp_w * t_w * t_w) >>> 32) + offset_val;
      endcase
      if (r > SAMPLE_MAX) begin
        r = SAMPLE_MAX;
      end else if (r < SAMPLE_MIN) begin
        r = SAMPLE_MIN;
      end
      return r[31:0];
    endfunction

    function void note_step(logic signed [15:0] ts);
      expected_samples.push_back(predict_sample(ts));
    endfunction

    function void check_sample(logic signed [31:0] got);
      logic signed [31:0] want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected sample %0d", got);
        end
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("sample mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_time_step = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_sample;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  sample_scoreboard sb = new();
  int in_idle_pct = 38;
  int out_idle_pct = 38;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  test_waveform_generator #(
    .SINE_TABLE_BITS(SINE_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_time_step(in_time_step),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_sample(out_sample);
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  function automatic logic signed [15:0] pick_step();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return $signed(16'($urandom_range(16))) - 16'sd8;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_wide();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(200)) - 32'd100;
      3:       return $urandom() >> $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic program_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, data);
  endtask

  task automatic send_step(input logic signed [15:0] ts);
    in_valid <= 1'b1;
    in_time_step <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_step(ts);
  endtask

  task automatic run_items(input int count);
    repeat (count) begin
      while ($urandom_range(99) < in_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      send_step(pick_step());
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int          p;
    logic [31:0] word;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_reg(REG_WAVEFORM, 32'(WAVE_STEP));
    program_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
    program_reg(REG_FREQUENCY, 32'h0000_FFFF);
    program_reg(REG_OFFSET, 32'h7FFF_FFFF);
    program_reg(REG_PHASE, 32'h0000_0000);
    cfg_valid <= 1'b0;
    send_step(16'sd0);
    send_step(-16'sd1);
    send_step(16'sh7FFF);
    in_valid <= 1'b0;
    drain();

    program_reg(REG_WAVEFORM, 32'(WAVE_RAMP));
    program_reg(REG_AMPLITUDE, 32'h8000_0000);
    program_reg(REG_OFFSET, 32'h8000_0000);
    cfg_valid <= 1'b0;
    send_step(16'sh7FFF);
    send_step(16'sh8000);
    send_step(16'sh8000);
    send_step(16'sh8000);
    in_valid <= 1'b0;
    drain();

    program_reg(REG_WAVEFORM, 32'hFFFF_FFFC | 32'(WAVE_PARABOLA));
    program_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
    program_reg(REG_OFFSET, 32'h0000_0000);
    cfg_valid <= 1'b0;
    send_step(16'sh7FFF);
    send_step(16'sh7FFF);
    send_step(16'sh8000);
    in_valid <= 1'b0;
    drain();

    program_reg(REG_WAVEFORM, 32'hABCD_0000 | 32'(WAVE_SINE));
    program_reg(REG_FREQUENCY, 32'h1234_FFFF);
    program_reg(REG_PHASE, 32'h5A5A_C000);
    cfg_valid <= 1'b0;
    send_step(16'sd0);
    send_step(16'sd1);
    send_step(16'sh7FFF);
    send_step(16'sh8000);
    in_valid <= 1'b0;
    drain();

    program_reg(REG_INDEX_MAX, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_step(16'sd100);
    send_step(-16'sd3);
    in_valid <= 1'b0;
    drain();

    for (p = 0; p < 12; p++) begin
      in_idle_pct = (p == 3) ? 0 : 38;
      out_idle_pct = (p == 3) ? 0 : 38;
      if (p % 6 == 5) begin
        program_reg(3'($urandom_range(int'(REG_INDEX_MAX), int'(REG_PHASE) + 1)),
                    $urandom());
      end else begin
        word = $urandom();
        word[1:0] = 2'(p);
        program_reg(REG_WAVEFORM, word);
        if ($urandom_range(3) != 0) program_reg(REG_AMPLITUDE, pick_wide());
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(3))
            0:       program_reg(REG_FREQUENCY, 32'h0000_0000);
            1:       program_reg(REG_FREQUENCY, 32'hFFFF_FFFF);
            default: program_reg(REG_FREQUENCY, $urandom());
          endcase
        end
        if ($urandom_range(3) != 0) program_reg(REG_OFFSET, pick_wide());
        if ($urandom_range(3) != 0) program_reg(REG_PHASE, $urandom());
      end
      cfg_valid <= 1'b0;
      if (p == 7) begin
        hold_request = 1'b1;
      end
      run_items(PHASE_ITEMS);
      drain();
    end

    in_idle_pct = 0;
    out_idle_pct = 0;
    program_reg(REG_WAVEFORM, 32'(WAVE_STEP));
    program_reg(REG_AMPLITUDE, 32'd1000);
    program_reg(REG_OFFSET, 32'hFFFF_FFF9);
    cfg_valid <= 1'b0;
    repeat (16) send_step(16'sh8000);
    send_step(16'sd1);
    in_valid <= 1'b0;
    drain();

    program_reg(REG_OFFSET, 32'd5);
    cfg_valid <= 1'b0;
    repeat (16) send_step(16'sh7FFF);
    send_step(-16'sd1);
    in_valid <= 1'b0;
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: test_waveform_generator.f
sv/twg_pkg.sv
sv/test_waveform_generator.sv
test/testbench.sv
